[rtl/capture_transition_extractor_defines.svh]
// Assertion macros for the capture transition extractor.
`ifndef CAPTURE_TRANSITION_EXTRACTOR_DEFINES_SVH
`define CAPTURE_TRANSITION_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CTE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cte_pkg.sv]
// Shared types and constants of the capture transition extractor.
package cte_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int LA_W        = 3;
    localparam int PERIOD_W    = 10;
    localparam int TS_W        = 25;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = PERIOD_W;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 48;
    localparam int OUT_PAD_W   = TDATA_OUT_W - TS_W - 2 * SAMPLE_W;

    localparam logic [SAMPLE_W-1:0] FULL_MASK    = 8'hff;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd62;

    localparam logic [CFG_ADDR_W-1:0] REG_LOOKAHEAD = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD    = 1'b1;

    // One held or finished report.
    typedef struct packed {
        logic                valid;
        logic                done;
        logic                last;
        logic [SAMPLE_W-1:0] value;
        logic [SAMPLE_W-1:0] mask;
        logic [LA_W-1:0]     seen;
    } ent_t;

    // Broadcast to every cell when a sample is accepted mid-capture.
    typedef struct packed {
        logic                active;
        logic                fin;
        logic [LA_W-1:0]     la;
        logic [SAMPLE_W-1:0] sample;
    } step_t;

endpackage

[rtl/cte_cell.sv]
// One cell of the report chain: holds a report, filters its mask, hands it to its neighbor.
module cte_cell #(
    parameter int IDX_W = 15
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cte_pkg::step_t        step,
    input  logic                  shift,
    input  logic                  push,
    input  cte_pkg::ent_t         push_ent,
    input  logic [IDX_W-1:0]      push_idx,
    input  cte_pkg::ent_t         nbr_ent,
    input  logic [IDX_W-1:0]      nbr_idx,
    input  logic                  left_vafter,
    output cte_pkg::ent_t         upd_ent,
    output logic [IDX_W-1:0]      upd_idx,
    output logic                  vafter,
    output cte_pkg::ent_t         ent_q
);

    cte_pkg::ent_t     ent_reg;
    cte_pkg::ent_t     ent_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;

    always_comb begin
        upd_ent = ent_reg;
        upd_idx = idx_reg;
        if (step.active && ent_reg.valid && !ent_reg.done) begin
            if (ent_reg.seen < step.la) begin
                upd_ent.mask = ent_reg.mask & ~(ent_reg.value ^ step.sample);
                upd_ent.seen = ent_reg.seen + cte_pkg::LA_W'(1);
            end
            if (step.fin || (upd_ent.seen >= step.la)) begin
                upd_ent.done = 1'b1;
            end
        end
    end

    assign vafter = shift ? nbr_ent.valid : ent_reg.valid;

    always_comb begin
        if (shift) begin
            ent_next = nbr_ent;
            idx_next = nbr_idx;
        end else begin
            ent_next = upd_ent;
            idx_next = upd_idx;
        end
        if (push && !vafter && left_vafter) begin
            ent_next = push_ent;
            idx_next = push_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg.valid <= 1'b0;
        end else begin
            ent_reg <= ent_next;
            idx_reg <= idx_next;
        end
    end

    assign ent_q = ent_reg;

endmodule

[rtl/cte_out_stage.sv]
// Output register: timestamp multiply and result request hold.
module cte_out_stage #(
    parameter int IDX_W = 15
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  cte_pkg::ent_t                        head_ent,
    input  logic [IDX_W-1:0]                     head_idx,
    input  logic [cte_pkg::PERIOD_W-1:0]         period,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [cte_pkg::TDATA_OUT_W-1:0]      m_tdata,
    output logic                                 m_tlast,
    output logic                                 pop
);

    localparam int PROD_W = IDX_W + cte_pkg::PERIOD_W;

    logic [PROD_W-1:0]                   prod;
    logic [cte_pkg::TS_W-1:0]            ts;
    logic                                m_tvalid_reg;
    logic [cte_pkg::TDATA_OUT_W-1:0]     m_tdata_reg;
    logic                                m_tlast_reg;

    assign prod = {{cte_pkg::PERIOD_W{1'b0}}, head_idx} * {{IDX_W{1'b0}}, period};
    assign ts   = cte_pkg::TS_W'(prod);
    assign pop  = head_ent.valid && head_ent.done && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pop) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_tdata_reg <= {{cte_pkg::OUT_PAD_W{1'b0}}, head_ent.mask, head_ent.value, ts};
            m_tlast_reg <= head_ent.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[rtl/capture_transition_extractor.sv]
// Top level of the capture transition extractor: capture control, cell chain, output stage.
// Throughput: one sample and one result request per cycle, as s_tready and m_tready allow.
// Release path: a report is written or marked done in its cell at the accepting edge of the
// sample that releases it, and is registered onto m_tdata once it heads the chain.
// Input stalls only while all MAX_LOOKAHEAD+2 cells of the chain are occupied.
// Reset is synchronous: chain empty, no capture open, lookahead 0, period 62 ns.
`include "capture_transition_extractor_defines.svh"

module capture_transition_extractor #(
    parameter int MAX_LOOKAHEAD = 7,
    parameter int CAPTURE_DEPTH = 32768
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [cte_pkg::TDATA_IN_W-1:0]        s_tdata,   // [7:0] sample
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [24:0] timestamp, [32:25] sample_value, [40:33] change_mask, [47:41] zero
    output logic [cte_pkg::TDATA_OUT_W-1:0]       m_tdata,
    output logic                                  m_tlast,
    input  logic                                  cfg_wr_en,
    input  logic [cte_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [cte_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    localparam int NCELL = MAX_LOOKAHEAD + 2;
    localparam int IDX_W = $clog2(CAPTURE_DEPTH);
    localparam logic [IDX_W-1:0] SAT_IDX = IDX_W'(CAPTURE_DEPTH - 1);

    logic [cte_pkg::LA_W-1:0]      lookahead_reg;
    logic [cte_pkg::PERIOD_W-1:0]  period_reg;
    logic                          first_seen_reg;
    logic                          first_seen_next;
    logic [cte_pkg::SAMPLE_W-1:0]  prev_reg;
    logic [cte_pkg::SAMPLE_W-1:0]  prev_next;
    logic [IDX_W-1:0]              sidx_reg;
    logic [IDX_W-1:0]              sidx_next;

    logic                          s_accept;
    logic [cte_pkg::SAMPLE_W-1:0]  sample;
    logic [cte_pkg::LA_W-1:0]      la;
    cte_pkg::step_t                step;
    logic                          push;
    cte_pkg::ent_t                 push_ent;
    logic [IDX_W-1:0]              push_idx;
    logic                          shift;

    cte_pkg::ent_t                 upd_ent [NCELL+1];
    logic [IDX_W-1:0]              upd_idx [NCELL+1];
    cte_pkg::ent_t                 q_ent   [NCELL];
    logic [IDX_W-1:0]              q_idx   [NCELL];
    logic                          vafter  [NCELL+1];

    assign sample   = s_tdata[cte_pkg::SAMPLE_W-1:0];
    assign s_tready = !q_ent[NCELL-1].valid;
    assign s_accept = s_tvalid && s_tready;
    assign la = (int'(lookahead_reg) > MAX_LOOKAHEAD) ? cte_pkg::LA_W'(MAX_LOOKAHEAD)
                                                      : lookahead_reg;

    assign step.active = s_accept && first_seen_reg;
    assign step.fin    = s_tlast;
    assign step.la     = la;
    assign step.sample = sample;

    always_comb begin
        push           = 1'b0;
        push_idx       = sidx_reg;
        push_ent.valid = 1'b1;
        push_ent.done  = 1'b0;
        push_ent.last  = 1'b0;
        push_ent.value = sample;
        push_ent.mask  = sample ^ prev_reg;
        push_ent.seen  = '0;
        if (s_accept) begin
            if (!first_seen_reg) begin
                push          = 1'b1;
                push_idx      = '0;
                push_ent.mask = cte_pkg::FULL_MASK;
                push_ent.last = s_tlast;
                push_ent.done = 1'b1;
            end else if (s_tlast) begin
                push          = 1'b1;
                push_ent.mask = cte_pkg::FULL_MASK;
                push_ent.last = 1'b1;
                push_ent.done = 1'b1;
            end else if (sample != prev_reg) begin
                push          = 1'b1;
                push_ent.done = (la == '0);
            end
        end
    end

    always_comb begin
        first_seen_next = first_seen_reg;
        prev_next       = prev_reg;
        sidx_next       = sidx_reg;
        if (s_accept) begin
            if (s_tlast) begin
                first_seen_next = 1'b0;
                prev_next       = '0;
                sidx_next       = '0;
            end else if (!first_seen_reg) begin
                first_seen_next = 1'b1;
                prev_next       = sample;
                sidx_next       = (SAT_IDX > IDX_W'(1)) ? IDX_W'(1) : SAT_IDX;
            end else begin
                prev_next = sample;
                if (sidx_reg < SAT_IDX) begin
                    sidx_next = sidx_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lookahead_reg  <= '0;
            period_reg     <= cte_pkg::PERIOD_RESET;
            first_seen_reg <= 1'b0;
            prev_reg       <= '0;
            sidx_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    cte_pkg::REG_LOOKAHEAD: lookahead_reg <= cfg_wdata[cte_pkg::LA_W-1:0];
                    cte_pkg::REG_PERIOD:    period_reg    <= cfg_wdata[cte_pkg::PERIOD_W-1:0];
                    default: ;
                endcase
            end
            first_seen_reg <= first_seen_next;
            prev_reg       <= prev_next;
            sidx_reg       <= sidx_next;
        end
    end

    assign upd_ent[NCELL] = '0;
    assign upd_idx[NCELL] = '0;
    assign vafter[NCELL]  = 1'b0;

    genvar j;
    generate
        for (j = 0; j < NCELL; j++) begin : g_cell
            logic left_va;
            if (j == 0) begin : g_head
                assign left_va = 1'b1;
            end else begin : g_body
                assign left_va = vafter[j-1];
            end
            cte_cell #(
                .IDX_W(IDX_W)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .step        (step),
                .shift       (shift),
                .push        (push),
                .push_ent    (push_ent),
                .push_idx    (push_idx),
                .nbr_ent     (upd_ent[j+1]),
                .nbr_idx     (upd_idx[j+1]),
                .left_vafter (left_va),
                .upd_ent     (upd_ent[j]),
                .upd_idx     (upd_idx[j]),
                .vafter      (vafter[j]),
                .ent_q       (q_ent[j])
            );
            assign q_idx[j] = upd_idx[j];
        end
    endgenerate

    cte_out_stage #(
        .IDX_W(IDX_W)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_ent (q_ent[0]),
        .head_idx (q_idx[0]),
        .period   (period_reg),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .pop      (shift)
    );

    `CTE_ASSERT_IMP(a_chain_compact, aclk, aresetn, !q_ent[0].valid, !q_ent[1].valid, "cell chain has a gap at its head")
    `CTE_ASSERT_NXT(a_final_closes, aclk, aresetn, s_accept && s_tlast, !first_seen_reg && (sidx_reg == '0), "final sample did not close the capture")
    `CTE_ASSERT_IMP(a_open_index, aclk, aresetn, !first_seen_reg, (sidx_reg == '0) && (prev_reg == '0), "idle capture state not cleared")

endmodule
